// ----- rtl/bdpc_pkg.sv -----
`default_nettype none

package bdpc_pkg;

   // fixed field widths
   localparam int NOW_WIDTH         = 32;
   localparam int LONG_WIDTH        = 16;
   localparam int DEBOUNCE_WIDTH    = 8;
   localparam int CSR_INDEX_WIDTH   = 8;
   localparam int CSR_DATA_WIDTH    = 16;

   // default timestamp width inside the block
   localparam int TIME_WIDTH_DEFAULT = 32;

   // register values after reset
   localparam logic [LONG_WIDTH-1:0]     LONG_PRESS_RESET = LONG_WIDTH'(1000);
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET   = DEBOUNCE_WIDTH'(20);

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_MS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_MS   = CSR_INDEX_WIDTH'(1);

   // one poll of the pin
   typedef struct packed {
      logic                 pin_level;
      logic [NOW_WIDTH-1:0] now_ms;
   } poll_type;

   // input stage towards the classifier
   typedef struct packed {
      logic     valid;
      poll_type poll;
   } poll_stage_type;

   // one classified result
   typedef struct packed {
      logic short_press;
      logic long_held;
      logic long_once;
      logic raw_pressed;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/bdpc_if.sv -----
`default_nettype none

// poll channel
interface bdpc_req_if import bdpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 pin_level;
   logic [NOW_WIDTH-1:0] now_ms;

   modport source (output valid, output pin_level, output now_ms, input ready);
   modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// result channel
interface bdpc_rsp_if import bdpc_pkg::*; ();
   logic valid;
   logic ready;
   logic short_press;
   logic long_held;
   logic long_once;
   logic raw_pressed;

   modport source (output valid, output short_press, output long_held,
                   output long_once, output raw_pressed, input ready);
   modport sink   (input valid, input short_press, input long_held,
                   input long_once, input raw_pressed, output ready);
endinterface

// register write channel
interface bdpc_csr_if import bdpc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bdpc_in_stage.sv -----
`default_nettype none

module bdpc_in_stage import bdpc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           accept,
   input  wire logic           advance,
   input  wire poll_type       poll,
   output      poll_stage_type stage
);

   logic     valid_ff, valid_in;
   poll_type poll_ff, poll_in;

   // hold a transaction until the classifier takes it
   always_comb begin
      valid_in = valid_ff;
      poll_in  = poll_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         poll_in  = poll;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      poll_ff <= poll_in;
   end

   assign stage.valid = valid_ff;
   assign stage.poll  = poll_ff;

endmodule

`default_nettype wire

// ----- rtl/bdpc_core.sv -----
`default_nettype none

module bdpc_core import bdpc_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data,
   input  wire logic                       advance,
   input  wire poll_type                   poll,
   output      result_type                 result
);

   logic [LONG_WIDTH-1:0]     long_press_ff, long_press_in;
   logic [DEBOUNCE_WIDTH-1:0] debounce_ff, debounce_in;

   logic                  stable_ff, stable_in;
   logic                  prev_raw_ff, prev_raw_in;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic                  press_active_ff, press_active_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic                  long_flag_ff, long_flag_in;
   logic                  long_rep_ff, long_rep_in;

   logic [TIME_WIDTH-1:0] now_t;
   logic [TIME_WIDTH-1:0] since_change;
   logic [TIME_WIDTH-1:0] since_press;
   logic                  raw;
   logic                  short_out;
   logic                  once_out;

   assign raw   = poll.pin_level;
   assign now_t = TIME_WIDTH'(poll.now_ms);

   // register writes, unknown indexes dropped
   always_comb begin
      long_press_in = long_press_ff;
      debounce_in   = debounce_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LONG_PRESS_MS: begin
               long_press_in = csr_data[LONG_WIDTH-1:0];
            end
            CSR_DEBOUNCE_MS: begin
               debounce_in = csr_data[DEBOUNCE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // debounce and press classification for one poll
   always_comb begin
      stable_in       = stable_ff;
      prev_raw_in     = raw;
      change_time_in  = change_time_ff;
      press_active_in = press_active_ff;
      press_start_in  = press_start_ff;
      long_flag_in    = long_flag_ff;
      long_rep_in     = long_rep_ff;
      short_out       = 1'b0;
      once_out        = 1'b0;

      // long flag clears one poll after the debounced release
      if (stable_ff) begin
         long_flag_in = 1'b0;
         long_rep_in  = 1'b0;
      end

      // any raw edge restarts the stability timer
      if (raw != prev_raw_ff) begin
         change_time_in = now_t;
      end
      since_change = now_t - change_time_in;
      if (since_change > TIME_WIDTH'(debounce_ff)) begin
         stable_in = raw;
      end

      since_press = now_t - press_start_ff;

      // press start on debounced low
      if (!stable_in && !press_active_ff) begin
         press_active_in = 1'b1;
         press_start_in  = now_t;
      end

      // release, short if under the long time
      if (stable_in && press_active_ff) begin
         press_active_in = 1'b0;
         if (since_press < TIME_WIDTH'(long_press_ff)) begin
            short_out = 1'b1;
         end
      end

      // held past the long time
      if (press_active_ff && !stable_in) begin
         if (since_press > TIME_WIDTH'(long_press_ff)) begin
            long_flag_in = 1'b1;
            if (!long_rep_in) begin
               once_out    = 1'b1;
               long_rep_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         stable_ff       <= 1'b1;
         prev_raw_ff     <= 1'b1;
         change_time_ff  <= '0;
         press_active_ff <= 1'b0;
         press_start_ff  <= '0;
         long_flag_ff    <= 1'b0;
         long_rep_ff     <= 1'b0;
      end else begin
         long_press_ff <= long_press_in;
         debounce_ff   <= debounce_in;
         if (advance) begin
            stable_ff       <= stable_in;
            prev_raw_ff     <= prev_raw_in;
            change_time_ff  <= change_time_in;
            press_active_ff <= press_active_in;
            press_start_ff  <= press_start_in;
            long_flag_ff    <= long_flag_in;
            long_rep_ff     <= long_rep_in;
         end
      end
   end

   assign result.short_press = short_out;
   assign result.long_held   = long_flag_in;
   assign result.long_once   = once_out;
   assign result.raw_pressed = ~raw;

   // a debounced low level always has a press running
   a_low_has_press: assert property (@(posedge clock) disable iff (reset)
      !stable_ff |-> press_active_ff)
      else $error("debounced low without an active press");

   // the one-shot flag is only set together with the long flag
   a_rep_has_flag: assert property (@(posedge clock) disable iff (reset)
      long_rep_ff |-> long_flag_ff)
      else $error("long press reported without long flag");

   // a short press and a long pulse never come from the same poll
   a_short_not_long: assert property (@(posedge clock) disable iff (reset)
      advance |-> !(short_out && once_out))
      else $error("short and long press in one poll");

   // the long pulse comes with the sticky flag
   a_once_with_held: assert property (@(posedge clock) disable iff (reset)
      (advance && once_out) |=> long_flag_ff)
      else $error("long pulse without sticky flag");

endmodule

`default_nettype wire

// ----- rtl/button_debounce_press_classifier_unit.sv -----
// Debounced push button with short / long press classification.
//
// req_bus carries one poll per transaction: the raw active-low pin level and
// a wrapping millisecond timestamp. rsp_bus returns exactly one result per
// poll, in order: short_press, long_held, long_once and raw_pressed.
// csr_bus writes register 0 (long_press_ms) and register 1 (debounce_ms); it
// is always ready and writes to other indexes are dropped. The user must write
// registers only while no poll is in flight; the block does not enforce this.
//
// The poll is captured in the input register at the accepting edge and passes
// through the classifier into the result register, which drives rsp_bus.valid,
// once that register has room. Throughput is one poll per cycle while the
// receiver does not stall; the classifier updates its state as each poll moves on.
//
// Synchronous reset empties both stages and loads long_press_ms = 1000,
// debounce_ms = 20 and a released button state.
// When the receiver stalls, the result register holds, the input register
// fills behind it and req_bus.ready then drops until rsp_bus.ready returns.
`default_nettype none

module button_debounce_press_classifier_unit import bdpc_pkg::*; #(
   parameter int TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   bdpc_req_if.sink   req_bus,
   bdpc_rsp_if.source rsp_bus,
   bdpc_csr_if.sink   csr_bus
);

   poll_stage_type stage;
   poll_type       poll;
   result_type     result;
   result_type     rsp_data_ff, rsp_data_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           advance;

   // transaction handshakes
   assign advance       = stage.valid && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !stage.valid || advance;
   assign accept        = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign poll.pin_level = req_bus.pin_level;
   assign poll.now_ms    = req_bus.now_ms;

   bdpc_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .advance (advance),
      .poll    (poll),
      .stage   (stage)
   );

   bdpc_core #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_bus.valid && csr_bus.ready),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .advance   (advance),
      .poll      (stage.poll),
      .result    (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.short_press = rsp_data_ff.short_press;
   assign rsp_bus.long_held   = rsp_data_ff.long_held;
   assign rsp_bus.long_once   = rsp_data_ff.long_once;
   assign rsp_bus.raw_pressed = rsp_data_ff.raw_pressed;

   // a poll only moves on when the result register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_bus.ready) |-> !advance)
      else $error("result register overwritten while stalled");

   // a poll accepted into an empty pipe reaches the result register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && !stage.valid && !rsp_valid_ff) |=> ##1 rsp_valid_ff)
      else $error("result missing after accepted poll");

   // a taken result with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bus.ready && !stage.valid) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import bdpc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int POLLS_PER_SET  = 185;

   logic clock;
   logic reset;

   bdpc_req_if req_bus ();
   bdpc_rsp_if rsp_bus ();
   bdpc_csr_if csr_bus ();

   button_debounce_press_classifier_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // register copies held by the predictor
   logic [LONG_WIDTH-1:0]     long_ms;
   logic [DEBOUNCE_WIDTH-1:0] deb_ms;

   // button state held by the predictor
   logic                 level_settled;
   logic                 last_pin;
   logic [NOW_WIDTH-1:0] edge_at_ms;
   logic                 in_press;
   logic [NOW_WIDTH-1:0] press_from_ms;
   logic                 held_long;
   logic                 long_told;

   // predicted classifications, oldest first
   result_type verdict_q[$];
   result_type verdict_due;

   logic [NOW_WIDTH-1:0] tick_ms;
   logic                 no_idle;
   int unsigned          ready_hold;
   int unsigned          quiet_cycles;
   int unsigned          fail_count;
   int unsigned          polls_sent;
   int unsigned          results_checked;
   int unsigned          shorts_seen;
   int unsigned          longs_seen;
   int unsigned          settings_written;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one poll through the classifier, updating the predicted state
   function automatic result_type classify_poll(input logic pin,
                                                input logic [NOW_WIDTH-1:0] now);
      result_type           verdict;
      logic [NOW_WIDTH-1:0] since;
      verdict = '0;
      if (level_settled) begin
         held_long = 1'b0;
         long_told = 1'b0;
      end
      if (pin != last_pin) edge_at_ms = now;
      since = now - edge_at_ms;
      if (since > NOW_WIDTH'(deb_ms)) level_settled = pin;
      last_pin = pin;
      if (!level_settled && !in_press) begin
         in_press = 1'b1;
         press_from_ms = now;
      end
      since = now - press_from_ms;
      if (level_settled && in_press) begin
         in_press = 1'b0;
         if (since < NOW_WIDTH'(long_ms)) verdict.short_press = 1'b1;
      end
      if (in_press && since > NOW_WIDTH'(long_ms)) begin
         held_long = 1'b1;
         if (!long_told) begin
            verdict.long_once = 1'b1;
            long_told = 1'b1;
         end
      end
      verdict.long_held = held_long;
      verdict.raw_pressed = ~pin;
      return verdict;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (roll < 70) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, actual %0b", name, want, got);
         fail_count++;
      end
   endtask

   // offer one poll transaction and record its predicted result
   task automatic send_poll(input logic pin, input logic [NOW_WIDTH-1:0] now);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.pin_level <= pin;
      req_bus.now_ms    <= now;
      do @(posedge clock); while (!req_bus.ready);
      verdict_q.push_back(classify_poll(pin, now));
      polls_sent++;
   endtask

   task automatic poll_after(input logic pin, input int unsigned step);
      tick_ms = tick_ms + NOW_WIDTH'(step);
      send_poll(pin, tick_ms);
   endtask

   // stop offering polls and let everything in flight come out
   task automatic quiesce();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      quiesce();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_LONG_PRESS_MS: long_ms = data[LONG_WIDTH-1:0];
         CSR_DEBOUNCE_MS:   deb_ms = data[DEBOUNCE_WIDTH-1:0];
         default: ;
      endcase
      settings_written++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // debounce goes in the low byte, the upper byte is junk
   task automatic apply_settings(input logic [LONG_WIDTH-1:0] lng,
                                 input logic [DEBOUNCE_WIDTH-1:0] dbc);
      write_csr(CSR_LONG_PRESS_MS, lng);
      write_csr(CSR_DEBOUNCE_MS, {8'($urandom()), dbc});
   endtask

   // one press with bounce, a held time near the interesting points, and release
   task automatic random_press();
      int unsigned lng, dbc, hold, spent, step, roll;
      lng = long_ms;
      dbc = deb_ms;
      roll = $urandom_range(0, 99);
      if (roll < 25) hold = $urandom_range(0, lng);
      else if (roll < 55 && lng > 0) hold = lng - 1 + $urandom_range(0, 2);
      else if (roll < 80) hold = lng + $urandom_range(1, lng + 50);
      else hold = $urandom_range(0, 2 * dbc + 5);
      // contact bounce on the way down
      repeat ($urandom_range(0, 3)) poll_after(1'($urandom_range(0, 1)), $urandom_range(0, dbc));
      poll_after(1'b1, $urandom_range(1, 4));
      poll_after(1'b0, $urandom_range(1, 4));
      // first poll past the debounce time starts the press
      poll_after(1'b0, dbc + 1);
      // held low, last poll lands exactly on the chosen time
      spent = 0;
      while (spent < hold) begin
         step = $urandom_range(1, (hold - spent + 1) / 2);
         spent += step;
         poll_after(1'b0, step);
      end
      // bounce on release, then settle high
      repeat ($urandom_range(0, 3)) poll_after(1'($urandom_range(0, 1)), $urandom_range(0, dbc));
      poll_after(1'b1, $urandom_range(1, 4));
      poll_after(1'b1, dbc + 1);
      repeat ($urandom_range(0, 2)) poll_after(1'b1, $urandom_range(1, 50));
   endtask

   // random pin levels with odd time jumps, including across the wrap
   task automatic noise_burst();
      int unsigned roll;
      repeat ($urandom_range(3, 10)) begin
         roll = $urandom_range(0, 9);
         if (roll == 0) tick_ms = NOW_WIDTH'($urandom());
         else if (roll == 1) tick_ms = '1 - NOW_WIDTH'($urandom_range(0, 40));
         poll_after(1'($urandom_range(0, 1)), $urandom_range(0, deb_ms + 2));
      end
   endtask

   // reset values, a long press and the flag clearing one poll after release
   task automatic test_reset_defaults();
      send_poll(1'b0, 32'd5);
      send_poll(1'b0, 32'd26);
      send_poll(1'b0, 32'd1027);
      send_poll(1'b1, 32'd1510);
      send_poll(1'b1, 32'd1531);
      send_poll(1'b1, 32'd1540);
   endtask

   // zero debounce, press of exactly the long time, then a short press
   task automatic test_zero_debounce_exact();
      apply_settings(16'd50, 8'd0);
      send_poll(1'b0, 32'd2000);
      send_poll(1'b0, 32'd2001);
      send_poll(1'b1, 32'd2050);
      send_poll(1'b1, 32'd2051);
      send_poll(1'b0, 32'd2100);
      send_poll(1'b0, 32'd2101);
      send_poll(1'b1, 32'd2110);
      send_poll(1'b1, 32'd2111);
   endtask

   // long time of zero: never short, long after one ms
   task automatic test_zero_long();
      write_csr(CSR_LONG_PRESS_MS, 16'd0);
      send_poll(1'b0, 32'd3000);
      send_poll(1'b0, 32'd3001);
      send_poll(1'b0, 32'd3002);
      send_poll(1'b1, 32'd3003);
      send_poll(1'b1, 32'd3004);
   endtask

   // largest settings, with the press spanning the timestamp wrap
   task automatic test_wrap_extremes();
      apply_settings(16'hFFFF, 8'hFF);
      send_poll(1'b0, 32'hFFFF_FFFF);
      send_poll(1'b0, 32'h0000_00FF);
      send_poll(1'b0, 32'h0001_00FE);
      send_poll(1'b0, 32'h0001_00FF);
      send_poll(1'b1, 32'h0001_0100);
      send_poll(1'b1, 32'h0001_0200);
      send_poll(1'b1, 32'h0001_0201);
   endtask

   // writes to indexes with no register behind them change nothing
   task automatic test_unknown_index();
      apply_settings(16'd10, 8'd3);
      write_csr(CSR_INDEX_WIDTH'(2), 16'hFFFF);
      write_csr(8'hFE, 16'h0000);
      write_csr(8'hFF, 16'hFFFF);
      send_poll(1'b0, 32'd5000);
      send_poll(1'b0, 32'd5004);
      send_poll(1'b0, 32'd5015);
   endtask

   // random presses and noise over a series of settings
   task automatic test_random();
      int unsigned target;
      tick_ms = NOW_WIDTH'($urandom());
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: apply_settings(LONG_PRESS_RESET, DEBOUNCE_RESET);
            1: apply_settings(16'd1, 8'd0);
            2: apply_settings(16'hFFFF, 8'hFF);
            3: apply_settings(16'd1, 8'hFF);
            4: apply_settings(16'hFFFF, 8'd0);
            5: apply_settings(16'($urandom_range(1, 300)), 8'($urandom_range(0, 30)));
            default: apply_settings(16'($urandom_range(1, 65535)), 8'($urandom()));
         endcase
         no_idle = (p == 3);
         target = polls_sent + POLLS_PER_SET;
         while (polls_sent < target) begin
            if ($urandom_range(0, 99) < 85) random_press();
            else noise_burst();
         end
      end
      no_idle = 1'b0;
   endtask

   // result side: random stalls, no new ones while no_idle is set
   always @(negedge clock) begin
      if (ready_hold > 0) ready_hold--;
      else if (no_idle) rsp_bus.ready <= 1'b1;
      else if ($urandom_range(0, 3) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = pick_gap() + 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold = $urandom_range(0, 8);
      end
   end

   // compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdict_q.size() == 0) begin
            $error("result arrived with no poll outstanding");
            fail_count++;
         end else begin
            verdict_due = verdict_q.pop_front();
            check_field("short_press", verdict_due.short_press, rsp_bus.short_press);
            check_field("long_held", verdict_due.long_held, rsp_bus.long_held);
            check_field("long_once", verdict_due.long_once, rsp_bus.long_once);
            check_field("raw_pressed", verdict_due.raw_pressed, rsp_bus.raw_pressed);
            results_checked++;
            if (rsp_bus.short_press) shorts_seen++;
            if (rsp_bus.long_once) longs_seen++;
         end
      end
   end

   // watchdog on cycles with no transaction anywhere
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // sequence
   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.pin_level = 1'b1;
      req_bus.now_ms    = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      no_idle           = 1'b0;
      ready_hold        = 0;
      quiet_cycles      = 0;
      fail_count        = 0;
      polls_sent        = 0;
      results_checked   = 0;
      shorts_seen       = 0;
      longs_seen        = 0;
      settings_written  = 0;
      tick_ms           = '0;
      long_ms           = LONG_PRESS_RESET;
      deb_ms            = DEBOUNCE_RESET;
      level_settled     = 1'b1;
      last_pin          = 1'b1;
      edge_at_ms        = '0;
      in_press          = 1'b0;
      press_from_ms     = '0;
      held_long         = 1'b0;
      long_told         = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_debounce_exact();
      test_zero_long();
      test_wrap_extremes();
      test_unknown_index();
      test_random();
      quiesce();

      $display("polls sent %0d, results checked %0d, register writes %0d",
               polls_sent, results_checked, settings_written);
      $display("short presses seen %0d, long presses seen %0d", shorts_seen, longs_seen);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
